// File: design/rau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;
  localparam int unsigned WordWidth = 32;

  typedef enum logic [2:0] {
    OpNorm = 3'd0, OpAdd = 3'd1, OpSub = 3'd2, OpMul = 3'd3,
    OpDiv = 3'd4, OpNeg = 3'd5, OpCmp = 3'd6, OpNone = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    StOk = 2'd0, StZero = 2'd1, StOvf = 2'd2, StRsvd = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CmpLess = 2'd0, CmpEqual = 2'd1, CmpGreater = 2'd2, CmpRsvd = 2'd3
  } cmp_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_num;
    logic [30:0]        result_den;
    logic [1:0]         status;
    logic [1:0]         compare_result;
  } rsp_t;
endpackage
`default_nettype wire

// File: design/rau_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module rau_mul (
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [63:0] p_o
);
  assign p_o = a_i * b_i;
endmodule
`default_nettype wire

// File: design/rau_div.sv
`timescale 1ns / 1ps
`default_nettype none
module rau_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [63:0] divisor_i,
  output logic             busy_o,
  output logic      [63:0] quot_o,
  output logic      [63:0] rem_o
);
  logic [63:0] quot_q, rem_q, dvs_q;
  logic [6:0]  cnt_q;
  logic        busy_q;
  logic [64:0] trial;

  assign trial = {rem_q, quot_q[63]} - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 7'd0;
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_q <= trial[63:0];
        quot_q <= {quot_q[62:0], 1'b1};
      end else begin
        rem_q <= {rem_q[62:0], quot_q[63]};
        quot_q <= {quot_q[62:0], 1'b0};
      end
      cnt_q <= cnt_q + 7'd1;
      if (cnt_q == 7'd63) busy_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

// File: design/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  | ports                     | handshake
// request  | req_i (rau_pkg::req_t)    | start_i high and busy_o low
// result   | rsp_o (rau_pkg::rsp_t)    | done_o high for one cycle
// Sequencing: three products pass in turn through one shared 32x32 multiplier
// (SP0, SP1, SP2); each Euclid step and each final division uses the shared radix-2
// divider, and done_o rises from SOut after the last division.
// Compare, OpNone, zero and divide-by-zero cases skip the divider (SPrep to SOut).
// Reset clears sequencer and divider control; busy_o holds until the result
// cycle, and the receiver cannot stall.
module rational_arithmetic_unit #(
  parameter int unsigned WORD_WIDTH = rau_pkg::WordWidth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire rau_pkg::req_t req_i,
  output logic               busy_o,
  output logic               done_o,
  output rau_pkg::rsp_t      rsp_o
);
  typedef enum logic [3:0] {
    SIdle, SP0, SP1, SP2, SPrep, SGcd, SGcdW, SDivN, SDivNW, SDivD, SDivDW, SOut
  } state_e;

  localparam logic [63:0] MaxPos = (64'd1 << (WORD_WIDTH - 1)) - 64'd1;

  state_e state_q;
  rau_pkg::req_t req_q;
  logic [63:0] p0_q, p1_q, p2_q, x_q, y_q, n_q, g_q;
  logic        neg_q;
  logic [31:0] ma_q, mb_q;
  logic [31:0] m_a, m_b;
  logic [63:0] m_p;
  logic        done_q;
  rau_pkg::rsp_t rsp_q;
  logic        d_start, d_busy;
  logic [63:0] d_dvd, d_dvs, d_quo, d_rem;
  logic        s0_q, s1_q, s2_q;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (32'd0 - v) : v;
  endfunction

  assign m_a = ma_q;
  assign m_b = mb_q;

  rau_mul u_mul (.a_i(m_a), .b_i(m_b), .p_o(m_p));

  rau_div u_div (
    .clk_i, .rst_ni, .start_i(d_start), .dividend_i(d_dvd), .divisor_i(d_dvs),
    .busy_o(d_busy), .quot_o(d_quo), .rem_o(d_rem)
  );

  always_comb begin
    d_start = (state_q == SGcd && y_q != '0) || state_q == SDivN || state_q == SDivD;
    d_dvd = (state_q == SGcd) ? x_q : ((state_q == SDivN) ? n_q : y_q);
    d_dvs = (state_q == SGcd) ? y_q : g_q;
  end

  logic [63:0] sum_pm;
  logic        sum_neg, den_neg;
  logic        pn, qn;

  always_comb begin
    pn = req_q.a_num[31] ^ req_q.b_den[31];
    qn = req_q.b_num[31] ^ req_q.a_den[31] ^ (req_q.operation == rau_pkg::OpSub);
    if (p0_q == '0) pn = 1'b0;
    if (p1_q == '0) qn = (req_q.operation == rau_pkg::OpSub);
    if (pn == qn) begin
      sum_pm = p0_q + p1_q; sum_neg = pn;
    end else if (p0_q >= p1_q) begin
      sum_pm = p0_q - p1_q; sum_neg = pn;
    end else begin
      sum_pm = p1_q - p0_q; sum_neg = qn;
    end
    den_neg = req_q.a_den[31] ^ req_q.b_den[31];
  end

  logic signed [64:0] cx, cy;
  always_comb begin
    cx = (req_q.a_num[31] ^ req_q.a_den[31]) && p0_q != '0 ?
         -$signed({1'b0, p0_q}) : $signed({1'b0, p0_q});
    cy = (req_q.b_num[31] ^ req_q.b_den[31]) && p1_q != '0 ?
         -$signed({1'b0, p1_q}) : $signed({1'b0, p1_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        SIdle: if (start_i) begin
          req_q <= req_i;
          ma_q <= mag32(req_i.a_num);
          case (req_i.operation)
            rau_pkg::OpMul: mb_q <= mag32(req_i.b_num);
            rau_pkg::OpNorm, rau_pkg::OpNeg: mb_q <= 32'd1;
            default: mb_q <= mag32(req_i.b_den);
          endcase
          state_q <= SP0;
        end
        SP0: begin
          p0_q <= m_p;
          ma_q <= mag32(req_q.b_num);
          mb_q <= mag32(req_q.a_den);
          if (req_q.operation == rau_pkg::OpMul) ma_q <= mag32(req_q.a_den);
          if (req_q.operation == rau_pkg::OpMul) mb_q <= mag32(req_q.b_den);
          state_q <= SP1;
        end
        SP1: begin
          p1_q <= m_p;
          ma_q <= mag32(req_q.a_den);
          mb_q <= mag32(req_q.b_den);
          if (req_q.operation == rau_pkg::OpDiv) mb_q <= mag32(req_q.b_num);
          state_q <= SP2;
        end
        SP2: begin
          p2_q <= m_p;
          state_q <= SPrep;
        end
        SPrep: begin
          rsp_q.result_num <= '0;
          rsp_q.result_den <= 31'd1;
          rsp_q.compare_result <= rau_pkg::CmpLess;
          rsp_q.status <= rau_pkg::StOk;
          state_q <= SOut;
          case (req_q.operation)
            rau_pkg::OpNorm, rau_pkg::OpNeg: begin
              if (req_q.a_den == '0) rsp_q.status <= rau_pkg::StZero;
              else if (req_q.a_num != '0) begin
                n_q <= p0_q; y_q <= {32'd0, mag32(req_q.a_den)};
                neg_q <= req_q.a_num[31] ^ req_q.a_den[31] ^
                         (req_q.operation == rau_pkg::OpNeg);
                x_q <= p0_q; g_q <= {32'd0, mag32(req_q.a_den)};
                state_q <= SGcd;
              end
            end
            rau_pkg::OpNone: ;
            default: begin
              if (req_q.a_den == '0 || req_q.b_den == '0) begin
                rsp_q.status <= rau_pkg::StZero;
                if (req_q.operation == rau_pkg::OpCmp)
                  rsp_q.compare_result <= rau_pkg::CmpEqual;
              end else if (req_q.operation == rau_pkg::OpCmp) begin
                rsp_q.compare_result <= (cx < cy) ? rau_pkg::CmpLess :
                  ((cx == cy) ? rau_pkg::CmpEqual : rau_pkg::CmpGreater);
              end else if (req_q.operation == rau_pkg::OpDiv && req_q.b_num == '0) begin
                rsp_q.status <= rau_pkg::StZero;
              end else if (req_q.operation == rau_pkg::OpMul) begin
                if (p0_q != '0) begin
                  n_q <= p0_q; x_q <= p0_q; y_q <= p1_q; g_q <= p1_q;
                  neg_q <= req_q.a_num[31] ^ req_q.b_num[31] ^ den_neg;
                  state_q <= SGcd;
                end
              end else if (req_q.operation == rau_pkg::OpDiv) begin
                if (p0_q != '0) begin
                  n_q <= p0_q; x_q <= p0_q; y_q <= p2_q; g_q <= p2_q;
                  neg_q <= req_q.a_num[31] ^ req_q.b_den[31] ^
                           req_q.a_den[31] ^ req_q.b_num[31];
                  state_q <= SGcd;
                end
              end else if (sum_pm != '0) begin
                n_q <= sum_pm; x_q <= sum_pm; y_q <= p2_q; g_q <= p2_q;
                neg_q <= sum_neg ^ den_neg;
                state_q <= SGcd;
              end
            end
          endcase
        end
        SGcd: begin
          if (y_q == '0) begin
            y_q <= g_q;
            g_q <= x_q;
            state_q <= SDivN;
          end else begin
            state_q <= SGcdW;
          end
        end
        SGcdW: if (!d_busy) begin
          x_q <= y_q;
          y_q <= d_rem;
          state_q <= SGcd;
        end
        SDivN: state_q <= SDivNW;
        SDivNW: if (!d_busy) begin
          n_q <= d_quo;
          state_q <= SDivD;
        end
        SDivD: state_q <= SDivDW;
        SDivDW: if (!d_busy) begin
          if (d_quo > MaxPos || (neg_q ? n_q > MaxPos + 64'd1 : n_q > MaxPos)) begin
            rsp_q.status <= rau_pkg::StOvf;
          end else begin
            rsp_q.result_num <= neg_q ? (32'd0 - n_q[31:0]) : n_q[31:0];
            rsp_q.result_den <= d_quo[30:0];
          end
          state_q <= SOut;
        end
        SOut: begin
          done_q <= 1'b1;
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign busy_o = (state_q != SIdle);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q <= 1'b0; s1_q <= 1'b0; s2_q <= 1'b0;
    end else begin
      s0_q <= start_i && !busy_o; s1_q <= s0_q; s2_q <= s1_q;
    end
  end

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("not busy");
  a_no_early_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_q || s1_q || s2_q) |-> !done_o) else $error("early done");
  a_den_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status != rau_pkg::StOk |-> rsp_o.result_den == 31'd1)
    else $error("bad den");
endmodule
`default_nettype wire

// File: sim/rau_checker.sv
`timescale 1ns / 1ps
module rau_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           busy_i,
  input  rau_pkg::req_t  req_i,
  input  logic           done_i,
  input  rau_pkg::rsp_t  rsp_i,
  output int             fail_count_o,
  output int             pending_o,
  output int             ops_seen_o [8],
  output int             results_seen_o
);
  import rau_pkg::*;

  rsp_t expected_results[$];

  assign pending_o = expected_results.size();

  function automatic logic [63:0] magnitude(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic rsp_t make_rsp(input logic [31:0] num, input logic [30:0] den,
                                    input status_e st, input cmp_e cmp);
    rsp_t r;
    r.result_num = num;
    r.result_den = den;
    r.status = st;
    r.compare_result = cmp;
    return r;
  endfunction

  function automatic rsp_t reduce_fraction(input logic nneg, input logic [63:0] nmag,
                                           input logic dneg, input logic [63:0] dmag);
    logic [63:0] x, y, t, n, d;
    logic neg;
    if (dmag == 0) return make_rsp(0, 1, StZero, CmpLess);
    if (nmag == 0) return make_rsp(0, 1, StOk, CmpLess);
    x = nmag;
    y = dmag;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    n = nmag / x;
    d = dmag / x;
    neg = nneg != dneg;
    if (d > 64'h7FFF_FFFF || (neg ? n > 64'h8000_0000 : n > 64'h7FFF_FFFF))
      return make_rsp(0, 1, StOvf, CmpLess);
    return make_rsp(neg ? 32'(-n) : n[31:0], d[30:0], StOk, CmpLess);
  endfunction

  function automatic rsp_t predict_rational(input req_t rq);
    logic signed [63:0] an, ad, bn, bd, p, q, den;
    logic [63:0] pm, qm;
    logic pn, qn;
    op_e op;
    op = op_e'(rq.operation);
    an = rq.a_num;
    ad = rq.a_den;
    bn = rq.b_num;
    bd = rq.b_den;
    if (op == OpNorm || op == OpNeg) begin
      if (ad == 0) return make_rsp(0, 1, StZero, CmpLess);
      return reduce_fraction((an < 0) != (op == OpNeg), magnitude(an), ad < 0, magnitude(ad));
    end
    if (op == OpNone) return make_rsp(0, 1, StOk, CmpLess);
    if (ad == 0 || bd == 0)
      return make_rsp(0, 1, StZero, op == OpCmp ? CmpEqual : CmpLess);
    case (op)
      OpCmp: begin
        if (ad < 0) begin an = -an; ad = -ad; end
        if (bd < 0) begin bn = -bn; bd = -bd; end
        p = an * bd;
        q = bn * ad;
        return make_rsp(0, 1, StOk, p < q ? CmpLess : (p == q ? CmpEqual : CmpGreater));
      end
      OpAdd, OpSub: begin
        p = an * bd;
        q = bn * ad;
        den = ad * bd;
        pn = p < 0;
        qn = (q < 0) != (op == OpSub);
        pm = magnitude(p);
        qm = magnitude(q);
        if (pn == qn) return reduce_fraction(pn, pm + qm, den < 0, magnitude(den));
        if (pm >= qm) return reduce_fraction(pn, pm - qm, den < 0, magnitude(den));
        return reduce_fraction(qn, qm - pm, den < 0, magnitude(den));
      end
      OpMul: begin
        p = an * bn;
        den = ad * bd;
        return reduce_fraction(p < 0, magnitude(p), den < 0, magnitude(den));
      end
      default: begin
        if (bn == 0) return make_rsp(0, 1, StZero, CmpLess);
        p = an * bd;
        den = ad * bn;
        return reduce_fraction(p < 0, magnitude(p), den < 0, magnitude(den));
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    results_seen_o = 0;
    foreach (ops_seen_o[i]) ops_seen_o[i] = 0;
  end

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && start_i && !busy_i) begin
      expected_results.push_back(predict_rational(req_i));
      ops_seen_o[req_i.operation]++;
    end
    if (rst_ni && done_i) begin
      results_seen_o++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transfer", rsp_i.result_num, 0);
      end else begin
        want = expected_results.pop_front();
        if (rsp_i.result_num !== want.result_num)
          report_mismatch("result_num", rsp_i.result_num, want.result_num);
        if (rsp_i.result_den !== want.result_den)
          report_mismatch("result_den", rsp_i.result_den, want.result_den);
        if (rsp_i.status !== want.status)
          report_mismatch("status", rsp_i.status, want.status);
        if (rsp_i.compare_result !== want.compare_result)
          report_mismatch("compare_result", rsp_i.compare_result, want.compare_result);
      end
    end
  end
endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import rau_pkg::*;

  localparam int RandomItems = 1000;
  localparam longint CycleLimit = 30_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  req_t req_i = '0;
  logic busy_o, done_o;
  rsp_t rsp_o;
  int fail_count, pending, results_seen;
  int ops_seen [8];
  longint cycles = 0;

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout with %0d results pending", pending);
      $display("testbench: errors");
      $finish;
    end
  end

  rational_arithmetic_unit u_top (
    .clk_i, .rst_ni, .start_i, .req_i, .busy_o, .done_o, .rsp_o
  );

  rau_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .req_i, .done_i(done_o), .rsp_i(rsp_o),
    .fail_count_o(fail_count), .pending_o(pending), .ops_seen_o(ops_seen),
    .results_seen_o(results_seen)
  );

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return $urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF;
      4, 5: return 32'($signed($urandom_range(0, 40)) - 20);
      6: return 32'($urandom_range(0, 4000)) - 32'd2000;
      7: return 32'($urandom_range(1, 12)) * 32'($urandom_range(1, 60000));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic [2:0] op, input logic [31:0] an, input logic [31:0] ad,
                           input logic [31:0] bn, input logic [31:0] bd, input int gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_i <= {op, an, ad, bn, bd};
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  initial begin
    logic [2:0] op;
    logic [31:0] s;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int o = 0; o < 8; o++) send_item(3'(o), 32'd6, 32'd4, 32'd3, 32'hFFFF_FFF7, 0);
    send_item(OpNorm, 32'h8000_0000, 32'hFFFF_FFFF, 0, 1, 1);
    send_item(OpNeg, 32'h8000_0000, 32'd1, 0, 0, 0);
    send_item(OpNorm, 32'd0, 32'h8000_0000, 0, 0, 2);
    send_item(OpNorm, 32'd5, 32'd0, 0, 0, 0);
    send_item(OpAdd, 32'd1, 32'd0, 32'd1, 32'd1, 0);
    send_item(OpCmp, 32'd1, 32'd2, 32'd1, 32'd0, 0);
    send_item(OpDiv, 32'd3, 32'd5, 32'd0, 32'd7, 3);
    send_item(OpMul, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1, 0);
    send_item(OpMul, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    send_item(OpAdd, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1, 0);
    send_item(OpSub, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    send_item(OpCmp, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_item(OpCmp, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    send_item(OpDiv, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 32'd1, 0);
    send_item(OpNeg, 32'd0, 32'hFFFF_FFFF, 0, 0, 0);
    for (int i = 0; i < RandomItems; i++) begin
      op = $urandom_range(0, 15) == 0 ? 3'd7 : 3'($urandom_range(0, 6));
      s = pick_word();
      if ($urandom_range(0, 5) == 0)
        send_item(op, s, pick_word(), s, pick_word(), $urandom_range(0, 14));
      else
        send_item(op, pick_word(), pick_word(), pick_word(), pick_word(),
                  $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14));
    end
    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("covered %0d results; per operation 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
             results_seen, ops_seen[0], ops_seen[1], ops_seen[2], ops_seen[3],
             ops_seen[4], ops_seen[5], ops_seen[6], ops_seen[7]);
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule

// File: sim.f
design/rau_pkg.sv
design/rau_mul.sv
design/rau_div.sv
design/rational_arithmetic_unit.sv
sim/rau_checker.sv
sim/testbench.sv
